// ===== hdl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// Used by spq_cell and sorted_priority_queue; depends on nothing else.
package spq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int VALUE_W         = 64;
	localparam int PRIO_W          = 32;
	localparam int OCC_W           = 5;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	typedef struct packed {
		logic                      req_type;
		logic signed [VALUE_W-1:0] item_value;
		logic signed [PRIO_W-1:0]  item_priority;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] out_value;
		status_t                   status;
		logic [OCC_W-1:0]          occupancy;
	} rsp_t;

	// One stored pair plus its valid flag, as handed between neighbor cells.
	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
	} entry_t;

	// Broadcast to every cell for one transfer.
	typedef struct packed {
		logic                      push;
		logic                      pop;
		logic signed [VALUE_W-1:0] value;
		logic signed [PRIO_W-1:0]  prio;
	} cmd_t;

endpackage

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: a row of spq_cell plus count and
// result register. Depends on spq_pkg and spq_cell.
//
// A bounded priority queue kept as a sorted row of QUEUE_DEPTH cells, head
// in cell 0. Every request (push or pop) gives one result in the cycle after its
// transfer; all cells compare the broadcast priority against their own and
// shift in the same cycle, so one request is taken every cycle while the
// result register is free or being drained. Pushes of equal priority leave
// last in, first out. A push into a full queue is dropped with status full;
// a pop of an empty queue returns zero with status empty. Occupancy is the
// entry count after the request, reported modulo 32.
module sorted_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                      accept;
	logic                      full;
	logic                      empty;
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_next;
	logic [CNT_W+OCC_W-1:0]    count_ext;
	cmd_t                      cmd;
	entry_t                    cells   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]    greater;
	logic [QUEUE_DEPTH-1:0]    valid_vec;
	entry_t                    tail_entry;
	logic                      rsp_valid_q;
	rsp_t                      rsp_q;
	rsp_t                      rsp_d;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign cmd.push  = accept && (req.req_type == REQ_PUSH) && !full;
	assign cmd.pop   = accept && (req.req_type == REQ_POP) && !empty;
	assign cmd.value = req.item_value;
	assign cmd.prio  = req.item_priority;

	assign tail_entry = '{valid: 1'b0, value: '0, prio: '0};

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_g;
		if (i == 0) begin : g_head
			assign prev_e = tail_entry;
			assign prev_g = 1'b1;
		end else begin : g_body
			assign prev_e = cells[i-1];
			assign prev_g = greater[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign next_e = tail_entry;
		end else begin : g_inner
			assign next_e = cells[i+1];
		end
		spq_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.prev_entry   (prev_e),
			.prev_greater (prev_g),
			.next_entry   (next_e),
			.entry        (cells[i]),
			.greater      (greater[i])
		);
		assign valid_vec[i] = cells[i].valid;
	end

	always_comb begin
		count_next = count_q;
		if (cmd.push) begin
			count_next = count_q + CNT_W'(1);
		end else if (cmd.pop) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	assign count_ext = {{OCC_W{1'b0}}, count_next};

	always_comb begin
		rsp_d.out_value = '0;
		rsp_d.occupancy = count_ext[OCC_W-1:0];
		if (req.req_type == REQ_PUSH) begin
			rsp_d.status = full ? ST_FULL : ST_PUSHED;
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.status    = ST_POPPED;
			rsp_d.out_value = cells[0].value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_valid_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("cell valid bits disagree with entry count");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.req_type == REQ_PUSH) && full |=>
			rsp.status == ST_FULL && $stable(count_q))
		else $error("push into full queue not dropped");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		cells[1].valid |-> cells[0].prio >= cells[1].prio)
		else $error("head cells out of priority order");
`endif

endmodule

// ===== hdl/spq_cell.sv =====
// One cell of the sorted queue: holds a pair and shifts it to a neighbor.
// Depends on spq_pkg for entry_t and cmd_t.
module spq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  spq_pkg::cmd_t   cmd,
	input  spq_pkg::entry_t prev_entry,
	input  logic            prev_greater,
	input  spq_pkg::entry_t next_entry,
	output spq_pkg::entry_t entry,
	output logic            greater
);
	import spq_pkg::*;

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic signed [PRIO_W-1:0]  prio_q;

	assign greater = valid_q && (prio_q > cmd.prio);

	assign entry.valid = valid_q;
	assign entry.value = value_q;
	assign entry.prio  = prio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.push) begin
			if (!greater) begin
				valid_q <= prev_greater ? 1'b1 : prev_entry.valid;
			end
		end else if (cmd.pop) begin
			valid_q <= next_entry.valid;
		end
	end

	// On push, keep above the insert point, take the new pair at it, shift down below it; on pop, shift up.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (!greater) begin
				if (prev_greater) begin
					value_q <= cmd.value;
					prio_q  <= cmd.prio;
				end else begin
					value_q <= prev_entry.value;
					prio_q  <= prev_entry.prio;
				end
			end
		end else if (cmd.pop) begin
			value_q <= next_entry.value;
			prio_q  <= next_entry.prio;
		end
	end

endmodule

// ===== sim/tb_sorted_priority_queue.sv =====
// Self-checking testbench for sorted_priority_queue: directed table, then random
// push/pop traffic with idle and stall phases, checked against a sorted-list model.
// Depends on spq_pkg and the sorted_priority_queue RTL.
module tb_sorted_priority_queue;
	import spq_pkg::*;

	localparam int QUEUE_DEPTH  = DEF_QUEUE_DEPTH;
	localparam int RANDOM_ITEMS = 750;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t rsp;
	} stim_row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_ready = 1'b0;
	req_t req       = '0;
	logic req_ready;
	logic rsp_valid;
	rsp_t rsp;

	logic signed [VALUE_W-1:0] model_value [QUEUE_DEPTH];
	logic signed [PRIO_W-1:0]  model_prio  [QUEUE_DEPTH];
	int                        model_count = 0;

	stim_row_t directed_rows[$];
	stim_row_t row_check_q[$];
	rsp_t      pending_rsp_q[$];
	int        err_count  = 0;
	int        idle_pct   = 0;
	int        stall_pct  = 0;
	int        hold_len   = 0;

	sorted_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("CHECK FAILED");
		$finish;
	end

	// Apply one request to the model queue and return the response it gives.
	function automatic rsp_t predict_response(req_t r);
		rsp_t res;
		int   pos;
		res = '0;
		if (r.req_type == REQ_PUSH) begin
			if (model_count >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < model_count && model_prio[pos] > r.item_priority)
					pos++;
				for (int i = model_count; i > pos; i--) begin
					model_value[i] = model_value[i-1];
					model_prio[i]  = model_prio[i-1];
				end
				model_value[pos] = r.item_value;
				model_prio[pos]  = r.item_priority;
				model_count++;
				res.status = ST_PUSHED;
			end
		end else if (model_count == 0) begin
			res.status = ST_EMPTY;
		end else begin
			res.out_value = model_value[0];
			for (int i = 1; i < model_count; i++) begin
				model_value[i-1] = model_value[i];
				model_prio[i-1]  = model_prio[i];
			end
			model_count--;
			res.status = ST_POPPED;
		end
		res.occupancy = OCC_W'(model_count);
		return res;
	endfunction

	function automatic req_t random_req(int push_pct);
		req_t r;
		r.req_type   = ($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_POP;
		r.item_value = {$urandom, $urandom};
		// Favor a narrow band so ties are frequent.
		case ($urandom_range(9))
			0:             r.item_priority = 32'sh7FFF_FFFF;
			1:             r.item_priority = 32'sh8000_0000;
			2, 3, 4, 5, 6: r.item_priority = int'($urandom_range(6)) - 3;
			default:       r.item_priority = $urandom;
		endcase
		return r;
	endfunction

	task automatic add_row(input logic kind, input logic signed [VALUE_W-1:0] value,
			input logic signed [PRIO_W-1:0] prio, input bit typed,
			input status_t st, input logic signed [VALUE_W-1:0] exp_value,
			input int occ);
		stim_row_t row;
		row.r.req_type      = kind;
		row.r.item_value    = value;
		row.r.item_priority = prio;
		row.typed           = typed;
		row.rsp.out_value   = exp_value;
		row.rsp.status      = st;
		row.rsp.occupancy   = OCC_W'(occ);
		directed_rows.push_back(row);
	endtask

	task automatic send_req(input req_t r);
		if ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (!req_ready);
	endtask

	// Hold the sender until every outstanding response has come back.
	task automatic drain;
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		stim_row_t row;
		rsp_t      pred;
		rsp_t      want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				row  = row_check_q.pop_front();
				pred = predict_response(req);
				pending_rsp_q.push_back(row.typed ? row.rsp : pred);
			end
			if (rsp_valid && rsp_ready) begin
				if (pending_rsp_q.size() == 0) begin
					$display("%0t: unexpected response value %0d status %0d occupancy %0d",
						$time, rsp.out_value, rsp.status, rsp.occupancy);
					err_count++;
				end else begin
					want = pending_rsp_q.pop_front();
					if (rsp.out_value !== want.out_value) begin
						$display("%0t: out_value expected %0d actual %0d",
							$time, want.out_value, rsp.out_value);
						err_count++;
					end
					if (rsp.status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, rsp.status);
						err_count++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$display("%0t: occupancy expected %0d actual %0d",
							$time, want.occupancy, rsp.occupancy);
						err_count++;
					end
				end
			end
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				rsp_ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		stim_row_t row;
		req_t      r;
		int        push_pct;

		add_row(REQ_POP, -64'sd1, 32'sd5, 1, ST_EMPTY, 0, 0);
		add_row(REQ_PUSH, 64'sh7FFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 1, ST_PUSHED, 0, 1);
		add_row(REQ_PUSH, 64'sh8000_0000_0000_0000, 32'sh8000_0000, 1, ST_PUSHED, 0, 2);
		// Tie with the head: the newer pair takes the head.
		add_row(REQ_PUSH, 64'sd1, 32'sh7FFF_FFFF, 1, ST_PUSHED, 0, 3);
		add_row(REQ_POP, 0, 0, 1, ST_POPPED, 64'sd1, 2);
		add_row(REQ_POP, 0, 0, 1, ST_POPPED, 64'sh7FFF_FFFF_FFFF_FFFF, 1);
		add_row(REQ_POP, 0, 0, 1, ST_POPPED, 64'sh8000_0000_0000_0000, 0);
		add_row(REQ_POP, 0, 0, 1, ST_EMPTY, 0, 0);
		for (int k = 0; k < QUEUE_DEPTH; k++)
			add_row(REQ_PUSH, -k, (k * 5) % 7 - 3, 0, ST_PUSHED, 0, 0);
		add_row(REQ_PUSH, 64'sd42, 32'sh7FFF_FFFF, 1, ST_FULL, 0, QUEUE_DEPTH);
		add_row(REQ_POP, 0, 0, 0, ST_POPPED, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			row_check_q.push_back(directed_rows[n]);
			send_req(directed_rows[n].r);
		end
		drain;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			case (n)
				100: hold_len = 60;
				150: drain;
				200: begin drain; idle_pct = 76; stall_pct = 0;  end
				350: begin drain; idle_pct = 0;  stall_pct = 76; end
				550: begin drain; idle_pct = 33; stall_pct = 33; end
				default: ;
			endcase
			// Swing between filling and emptying so both ends are reached.
			case ((n / 60) % 3)
				0:       push_pct = 75;
				1:       push_pct = 30;
				default: push_pct = 55;
			endcase
			r = random_req(push_pct);
			row.r     = r;
			row.typed = 1'b0;
			row.rsp   = '0;
			row_check_q.push_back(row);
			send_req(r);
		end

		drain;
		repeat (4) @(posedge clk);
		if (err_count == 0 && pending_rsp_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
